// File: rtl/core/piecewise_linear_curve_lookup_assert.svh
// Assertion macros for the curve lookup block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define PLCL_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("curve lookup check failed");

// a in this cycle implies b in the next cycle
`define PLCL_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("curve lookup check failed");

`endif

// File: rtl/core/plcl_pkg.sv
// Shared constants and codes for the curve lookup block.
// No dependencies.
package plcl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int CHANNELS_DEF   = 3;
    localparam int OUT_CHANNELS   = 3;

    localparam int DATA_W = 24;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CH_W   = 2;
    localparam int REG_W  = 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    // divider: numerator 2|p|+den, divisor 2den, quotient below 2^26
    localparam int PROD_W  = 50;
    localparam int DIV_N_W = 52;
    localparam int DIV_D_W = 26;
    localparam int DIV_Q_W = 26;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [REG_W-1:0] REG_COUNT_RED   = 2'd0;
    localparam logic [REG_W-1:0] REG_COUNT_GREEN = 2'd1;
    localparam logic [REG_W-1:0] REG_COUNT_BLUE  = 2'd2;

endpackage

// File: rtl/core/plcl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module plcl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/plcl_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on plcl_pkg for widths. Caller guarantees num < den * 2^DIV_Q_W.
module plcl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [plcl_pkg::DIV_N_W-1:0]  num,
    input  logic [plcl_pkg::DIV_D_W-1:0]  den,
    output logic                          busy,
    output logic                          done,
    output logic [plcl_pkg::DIV_Q_W-1:0]  quo
);

    localparam int SW = $clog2(plcl_pkg::DIV_Q_W);

    logic [plcl_pkg::DIV_D_W-1:0] rem_reg;
    logic [plcl_pkg::DIV_D_W-1:0] den_reg;
    logic [plcl_pkg::DIV_Q_W-1:0] low_reg;
    logic [plcl_pkg::DIV_Q_W-1:0] quo_reg;
    logic [SW-1:0]                step_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [plcl_pkg::DIV_D_W:0]   trial;
    logic                         fits;

    assign trial = {rem_reg, low_reg[plcl_pkg::DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == SW'(plcl_pkg::DIV_Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[plcl_pkg::DIV_N_W-1 -: plcl_pkg::DIV_D_W];
            low_reg <= num[plcl_pkg::DIV_Q_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? plcl_pkg::DIV_D_W'(trial - {1'b0, den_reg})
                            : trial[plcl_pkg::DIV_D_W-1:0];
            low_reg <= {low_reg[plcl_pkg::DIV_Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[plcl_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/core/piecewise_linear_curve_lookup.sv
// Piecewise-linear curve lookup, per-channel breakpoint tables in one RAM.
// Depends on plcl_pkg, plcl_ram, plcl_div and the assertion header.
//
//  channel  | group          | payload
//  ---------+----------------+-------------------------------------------
//  input    | s_axis_*       | tuser func; tdata channel, index, x, y, v
//  result   | m_axis_*       | tdata density red, green, blue
//  config   | cfg_we/index   | count_red, count_green, count_blue
//
// A load item writes the table RAM directly.
// An evaluate item walks the channels in turn: two end reads, a binary
// search of up to six probes, two neighbour reads, one multiply and a
// 26-step divide; the next item is accepted only once the sequencer is
// back in idle. The single RAM read port and the bit-serial divider make
// the walk sequential.
// Reset clears control and sets each count to 1; table contents are undefined until loaded.
// A stalled result stays in the output register; the next item is still
// accepted, and a new result waits until the old one is taken.
module piecewise_linear_curve_lookup #(
    parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF,
    parameter int CHANNELS   = plcl_pkg::CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: channel[1:0], point_index[7:2], point_x[31:8],
    //        point_y[55:32], log_exposure[79:56]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [plcl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: func[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: density_red[23:0], density_green[47:24], density_blue[71:48]
    output logic [plcl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [plcl_pkg::REG_W-1:0]        cfg_index,
    input  logic [plcl_pkg::CNT_W-1:0]        cfg_data
);

    localparam int DW = plcl_pkg::DATA_W;
    localparam int DEPTH = CHANNELS * MAX_POINTS;
    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int OC = plcl_pkg::OUT_CHANNELS;

    typedef enum logic [3:0] {
        S_IDLE, S_CH_START, S_R_FIRST, S_R_LAST, S_SEARCH, S_CMP,
        S_R_LO, S_R_HI, S_MUL, S_DIV_START, S_DIV_WAIT, S_FIN
    } state_t;

    // input fields
    logic                           in_func;
    logic [plcl_pkg::CH_W-1:0]      in_channel;
    logic [plcl_pkg::IDX_W-1:0]     in_index;
    logic signed [DW-1:0]           in_x;
    logic signed [DW-1:0]           in_y;
    logic signed [DW-1:0]           in_v;

    assign in_func    = s_axis_tuser;
    assign in_channel = s_axis_tdata[1:0];
    assign in_index   = s_axis_tdata[7:2];
    assign in_x       = s_axis_tdata[31:8];
    assign in_y       = s_axis_tdata[55:32];
    assign in_v       = s_axis_tdata[79:56];

    state_t                         state_reg;
    logic [plcl_pkg::CNT_W-1:0]     count_reg [OC];
    logic [plcl_pkg::CH_W-1:0]      ch_reg;
    logic signed [DW-1:0]           v_reg;
    logic [IW-1:0]                  lo_reg;
    logic [IW-1:0]                  hi_reg;
    logic signed [DW-1:0]           x0_reg;
    logic signed [DW-1:0]           y0_reg;
    logic signed [DW:0]             dy_reg;
    logic signed [DW:0]             num_reg;
    logic signed [DW:0]             den_reg;
    logic signed [plcl_pkg::PROD_W-1:0] prod_reg;
    logic                           neg_reg;
    logic [DW-1:0]                  res_reg [OC];
    logic                           out_valid_reg;
    logic [plcl_pkg::OUT_DATA_W-1:0] out_data_reg;

    // table RAM: {y, x}
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    logic [2*DW-1:0]                ram_rdata;
    logic signed [DW-1:0]           rd_x;
    logic signed [DW-1:0]           rd_y;

    logic                           in_acc;
    logic [NW-1:0]                  n_eff;
    logic [IW-1:0]                  last_idx;
    logic [IW-1:0]                  mid;
    logic [IW-1:0]                  rd_idx;
    logic signed [DW:0]             den_c;
    logic signed [DW:0]             num_c;
    logic [plcl_pkg::PROD_W-1:0]    prod_mag;
    logic [plcl_pkg::DIV_N_W-1:0]   div_num;
    logic [plcl_pkg::DIV_D_W-1:0]   div_den;
    logic                           div_start;
    logic                           div_busy;
    logic                           div_done;
    logic [plcl_pkg::DIV_Q_W-1:0]   div_quo;
    logic signed [plcl_pkg::DIV_Q_W:0] q_signed;
    logic [DW-1:0]                  interp;

    function automatic logic [NW-1:0] eff_count(input logic [plcl_pkg::CNT_W-1:0] c);
        logic [NW-1:0] r;
        if (c == '0)
        begin
            r = NW'(1);
        end
        else if (int'(c) > MAX_POINTS)
        begin
            r = NW'(MAX_POINTS);
        end
        else
        begin
            r = NW'(c);
        end
        return r;
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign n_eff    = eff_count(count_reg[ch_reg]);
    assign last_idx = IW'(n_eff - NW'(1));
    assign mid      = IW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    // loads only happen while idle; read data is used only while evaluating
    assign ram_we = in_acc && (in_func == plcl_pkg::FUNC_LOAD)
                    && (int'(in_channel) < CHANNELS)
                    && (int'(in_index) < MAX_POINTS);
    assign ram_waddr = AW'(int'(in_channel) * MAX_POINTS + int'(in_index));

    always_comb
    begin
        unique case (state_reg)
            S_R_FIRST: rd_idx = last_idx;
            S_SEARCH:  rd_idx = (lo_reg < hi_reg) ? mid : IW'(lo_reg - 1'b1);
            S_R_LO:    rd_idx = lo_reg;
            default:   rd_idx = '0;
        endcase
    end

    assign ram_raddr = AW'(int'(ch_reg) * MAX_POINTS + int'(rd_idx));
    assign rd_x      = ram_rdata[DW-1:0];
    assign rd_y      = ram_rdata[2*DW-1:DW];

    plcl_ram #(
        .WIDTH (2 * DW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_y, in_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign den_c = (DW+1)'(rd_x) - (DW+1)'(x0_reg);
    assign num_c = (DW+1)'(v_reg) - (DW+1)'(x0_reg);

    // round to nearest, ties away from zero: (2|p| + den) / (2 den)
    assign prod_mag  = neg_reg ? plcl_pkg::PROD_W'(-prod_reg)
                               : plcl_pkg::PROD_W'(prod_reg);
    assign div_num   = {1'b0, prod_mag, 1'b0} + plcl_pkg::DIV_N_W'(den_reg);
    assign div_den   = {den_reg[plcl_pkg::DIV_D_W-2:0], 1'b0};
    assign div_start = (state_reg == S_DIV_START);
    assign q_signed  = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign interp    = DW'(y0_reg + q_signed);

    plcl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OC; i++)
            begin
                count_reg[i] <= plcl_pkg::CNT_W'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                plcl_pkg::REG_COUNT_RED:   count_reg[0] <= cfg_data;
                plcl_pkg::REG_COUNT_GREEN: count_reg[1] <= cfg_data;
                plcl_pkg::REG_COUNT_BLUE:  count_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
        end
        else
        begin
            // S_FIN refills the output register itself
            if (out_valid_reg && m_axis_tready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (in_func == plcl_pkg::FUNC_EVAL))
                    begin
                        v_reg     <= in_v;
                        ch_reg    <= '0;
                        state_reg <= S_CH_START;
                    end
                end
                S_CH_START:
                begin
                    if (int'(ch_reg) >= CHANNELS)
                    begin
                        res_reg[ch_reg] <= '0;
                        if (int'(ch_reg) == OC - 1)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_R_FIRST;
                    end
                end
                S_R_FIRST:
                begin
                    if (v_reg <= rd_x)
                    begin
                        res_reg[ch_reg] <= rd_y;
                        state_reg <= (int'(ch_reg) == OC - 1) ? S_FIN : S_CH_START;
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_R_LAST;
                    end
                end
                S_R_LAST:
                begin
                    if (v_reg >= rd_x)
                    begin
                        res_reg[ch_reg] <= rd_y;
                        state_reg <= (int'(ch_reg) == OC - 1) ? S_FIN : S_CH_START;
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else
                    begin
                        lo_reg    <= IW'(1);
                        hi_reg    <= last_idx;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    state_reg <= (lo_reg < hi_reg) ? S_CMP : S_R_LO;
                end
                S_CMP:
                begin
                    if (rd_x >= v_reg)
                    begin
                        hi_reg <= mid;
                    end
                    else
                    begin
                        lo_reg <= IW'(mid + 1'b1);
                    end
                    state_reg <= S_SEARCH;
                end
                S_R_LO:
                begin
                    x0_reg    <= rd_x;
                    y0_reg    <= rd_y;
                    state_reg <= S_R_HI;
                end
                S_R_HI:
                begin
                    priority if (den_c <= 0 || num_c >= den_c)
                    begin
                        res_reg[ch_reg] <= rd_y;
                        state_reg <= (int'(ch_reg) == OC - 1) ? S_FIN : S_CH_START;
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else if (num_c <= 0)
                    begin
                        res_reg[ch_reg] <= y0_reg;
                        state_reg <= (int'(ch_reg) == OC - 1) ? S_FIN : S_CH_START;
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else
                    begin
                        dy_reg    <= (DW+1)'(rd_y) - (DW+1)'(y0_reg);
                        num_reg   <= num_c;
                        den_reg   <= den_c;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= dy_reg * num_reg;
                    neg_reg   <= dy_reg[DW];
                    state_reg <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        res_reg[ch_reg] <= interp;
                        state_reg <= (int'(ch_reg) == OC - 1) ? S_FIN : S_CH_START;
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {res_reg[2], res_reg[1], res_reg[0]};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "piecewise_linear_curve_lookup_assert.svh"

    // table writes never overlap an evaluation
    `PLCL_ASSERT_IMP(a_write_idle, ram_we, state_reg == S_IDLE)
    // divider runs only while the sequencer waits on it
    `PLCL_ASSERT_IMP(a_div_owned, div_busy, state_reg == S_DIV_WAIT)
    // search window never inverts
    `PLCL_ASSERT_IMP(a_search_order, state_reg == S_CMP, lo_reg < hi_reg)
    // an evaluate item always leaves idle
    `PLCL_ASSERT_NXT(a_eval_starts, in_acc && in_func == plcl_pkg::FUNC_EVAL,
        state_reg == S_CH_START)

endmodule
